FILE: src/rxbm_pkg.sv
package rxbm_pkg;

	// field widths
	localparam int unsigned VALUE_BITS  = 31;
	localparam int unsigned IDX_W       = 11;
	localparam int unsigned NUM_BUCKETS = 1024;
	localparam int unsigned SLOT_W      = 5;
	localparam int unsigned NODE_W      = 12;
	localparam int unsigned ADDR_W      = NODE_W + SLOT_W;
	localparam int unsigned MEM_DEPTH   = 1 << ADDR_W;
	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned SP_W        = 5;

	localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(VALUE_BITS - 1);
	localparam logic [IDX_W-1:0]  MAX_BC   = IDX_W'(NUM_BUCKETS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [NODE_W-1:0]     node_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DOWN,
		ST_LOAD_A,
		ST_LOAD_D,
		ST_ADD,
		ST_RIGHT_A,
		ST_RIGHT_D,
		ST_WRITE,
		ST_POP,
		ST_Q_START,
		ST_Q_POP,
		ST_Q_CHK,
		ST_Q_A,
		ST_Q_D,
		ST_MAX,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_CUR,
		SRC_LEFT,
		SRC_RIGHT
	} src_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic push_down;
		src_t src;
		logic ld_work;
		logic cnt_init;
		logic cnt_dec;
		logic v_ins;
		logic v_mem;
		logic add_step;
		logic mem_wr;
		logic pop;
		logic q_split;
		logic max_step;
	} cmd_t;

	typedef struct packed {
		logic leaf;
		logic sp_zero;
		logic cnt_zero;
		logic add_last;
		logic rdata_zero;
		logic q_empty;
		logic q_disjoint;
		logic q_contained;
		logic ins_ok;
		logic clr_last;
	} status_t;

endpackage

FILE: src/rxbm_if.sv
interface rxbm_req_if;
	import rxbm_pkg::*;
	logic   valid;
	logic   ready;
	logic   cmd;
	idx_t   bucket_index;
	value_t insert_value;
	idx_t   range_left;
	idx_t   range_right;
	modport source(output valid, cmd, bucket_index, insert_value, range_left, range_right,
		input ready);
	modport sink(input valid, cmd, bucket_index, insert_value, range_left, range_right,
		output ready);
endinterface

interface rxbm_rsp_if;
	import rxbm_pkg::*;
	logic   valid;
	logic   ready;
	value_t max_xor;
	modport source(output valid, max_xor, input ready);
	modport sink(input valid, max_xor, output ready);
endinterface

FILE: src/rxbm_ram.sv
module rxbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/rxbm_dp.sv
module rxbm_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_cmd,
	input  rxbm_pkg::idx_t   bucket_index,
	input  rxbm_pkg::value_t insert_value,
	input  rxbm_pkg::idx_t   range_left,
	input  rxbm_pkg::idx_t   range_right,
	input  logic             cfg_we,
	input  rxbm_pkg::idx_t   cfg_wdata,
	input  rxbm_pkg::cmd_t   cmd,
	output rxbm_pkg::status_t status,
	output rxbm_pkg::value_t max_xor
);
	import rxbm_pkg::*;

	idx_t   bc_q;
	idx_t   p_q, ql_q, qr_q;
	value_t val_q;
	node_t  cur_node_q;
	idx_t   cur_l_q, cur_r_q;
	node_t  stk_node_q [STACK_DEPTH];
	idx_t   stk_l_q [STACK_DEPTH];
	idx_t   stk_r_q [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;
	value_t work_q [VALUE_BITS];
	value_t v_q, acc_q;
	slot_t  j_q, cnt_q;
	addr_t  clr_addr_q;

	value_t rdata, wdata, wj, t_acc;
	addr_t  raddr, waddr;
	node_t  src_node, left_node, right_node;
	logic [IDX_W:0] sum_lr;
	idx_t   mid, cfg_clamped;
	logic   jv, we;
	logic [SP_W-1:0] sp_m1;

	assign left_node  = {cur_node_q[NODE_W-2:0], 1'b0};
	assign right_node = {cur_node_q[NODE_W-2:0], 1'b1};
	assign sum_lr     = {1'b0, cur_l_q} + {1'b0, cur_r_q};
	assign mid        = sum_lr[IDX_W:1];
	assign sp_m1      = sp_q - SP_W'(1);
	assign wj         = work_q[j_q];
	assign jv         = v_q[j_q];
	assign t_acc      = acc_q ^ work_q[cnt_q];

	// register value clamped to the legal bucket range
	always_comb begin
		cfg_clamped = cfg_wdata;
		if (cfg_wdata == '0) begin
			cfg_clamped = IDX_W'(1);
		end else if (cfg_wdata > MAX_BC) begin
			cfg_clamped = MAX_BC;
		end
	end

	// memory address and write data selection
	always_comb begin
		unique case (cmd.src)
			SRC_LEFT:  src_node = left_node;
			SRC_RIGHT: src_node = right_node;
			default:   src_node = cur_node_q;
		endcase
		raddr = {src_node, cnt_q};
		if (cmd.clr_wr) begin
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			waddr = {cur_node_q, cnt_q};
			wdata = work_q[cnt_q];
		end
		we = cmd.clr_wr | cmd.mem_wr;
	end

	rxbm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control registers: bucket count, stack pointer, clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q       <= MAX_BC;
			sp_q       <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				bc_q       <= cfg_clamped;
				clr_addr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.accept) begin
				sp_q <= req_cmd ? SP_W'(1) : '0;
			end else if (cmd.push_down) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.q_split) begin
				sp_q <= sp_q + SP_W'(2);
			end else if (cmd.pop) begin
				sp_q <= sp_m1;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q        <= bucket_index;
			val_q      <= insert_value;
			ql_q       <= (range_left == '0) ? IDX_W'(1) : range_left;
			qr_q       <= (range_right > bc_q) ? bc_q : range_right;
			cur_node_q <= NODE_W'(1);
			cur_l_q    <= IDX_W'(1);
			cur_r_q    <= bc_q;
			acc_q      <= '0;
			if (req_cmd) begin
				stk_node_q[0] <= NODE_W'(1);
				stk_l_q[0]    <= IDX_W'(1);
				stk_r_q[0]    <= bc_q;
				for (int i = 0; i < VALUE_BITS; i++) begin
					work_q[i] <= '0;
				end
			end
		end
		// descend towards the leaf of the inserted bucket
		if (cmd.push_down) begin
			stk_node_q[sp_q[SP_W-2:0]] <= cur_node_q;
			stk_l_q[sp_q[SP_W-2:0]]    <= cur_l_q;
			stk_r_q[sp_q[SP_W-2:0]]    <= cur_r_q;
			if (p_q <= mid) begin
				cur_node_q <= left_node;
				cur_r_q    <= mid;
			end else begin
				cur_node_q <= right_node;
				cur_l_q    <= mid + IDX_W'(1);
			end
		end
		// split a partly covered node into both children
		if (cmd.q_split) begin
			stk_node_q[sp_q[SP_W-2:0]] <= right_node;
			stk_l_q[sp_q[SP_W-2:0]]    <= mid + IDX_W'(1);
			stk_r_q[sp_q[SP_W-2:0]]    <= cur_r_q;
			stk_node_q[sp_q[SP_W-2:0] + 4'd1] <= left_node;
			stk_l_q[sp_q[SP_W-2:0] + 4'd1]    <= cur_l_q;
			stk_r_q[sp_q[SP_W-2:0] + 4'd1]    <= mid;
		end
		if (cmd.pop) begin
			cur_node_q <= stk_node_q[sp_m1[SP_W-2:0]];
			cur_l_q    <= stk_l_q[sp_m1[SP_W-2:0]];
			cur_r_q    <= stk_r_q[sp_m1[SP_W-2:0]];
		end
		// slot counter
		if (cmd.cnt_init) begin
			cnt_q <= TOP_SLOT;
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - SLOT_W'(1);
		end
		if (cmd.ld_work) begin
			work_q[cnt_q] <= rdata;
		end
		// one elimination step a cycle
		if (cmd.v_ins) begin
			v_q <= val_q;
			j_q <= TOP_SLOT;
		end else if (cmd.v_mem) begin
			v_q <= rdata;
			j_q <= TOP_SLOT;
		end else if (cmd.add_step) begin
			if (v_q != '0 && jv) begin
				if (wj != '0) begin
					v_q <= v_q ^ wj;
				end else begin
					work_q[j_q] <= v_q;
				end
			end
			if (j_q != '0) begin
				j_q <= j_q - SLOT_W'(1);
			end
		end
		// greedy maximum from the top slot down
		if (cmd.max_step && t_acc > acc_q) begin
			acc_q <= t_acc;
		end
	end

	always_comb begin
		status.leaf        = (cur_l_q == cur_r_q);
		status.sp_zero     = (sp_q == '0);
		status.cnt_zero    = (cnt_q == '0);
		status.add_last    = (v_q == '0) || (jv && wj == '0) || (j_q == '0);
		status.rdata_zero  = (rdata == '0);
		status.q_empty     = (ql_q > qr_q);
		status.q_disjoint  = (cur_r_q < ql_q) || (cur_l_q > qr_q);
		status.q_contained = (ql_q <= cur_l_q) && (cur_r_q <= qr_q);
		status.ins_ok      = (bucket_index != '0) && (bucket_index <= bc_q)
			&& (insert_value != '0);
		status.clr_last    = (clr_addr_q == '1);
	end

	assign max_xor = acc_q;
endmodule

FILE: src/rxbm_ctrl.sv
module rxbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_cmd,
	input  logic              rsp_ready,
	input  logic              cfg_we,
	input  rxbm_pkg::status_t status,
	output rxbm_pkg::cmd_t    cmd,
	output logic              req_ready,
	output logic              rsp_valid
);
	import rxbm_pkg::*;

	state_t state_q, state_d;
	logic   is_query_q, leaf_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (status.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) begin
					if (req_cmd) state_d = ST_Q_START;
					else if (status.ins_ok) state_d = ST_DOWN;
				end
			end
			ST_DOWN: if (status.leaf) state_d = ST_LOAD_A;
			ST_LOAD_A: state_d = ST_LOAD_D;
			ST_LOAD_D: begin
				if (!status.cnt_zero) state_d = ST_LOAD_A;
				else if (leaf_q) state_d = ST_ADD;
				else state_d = ST_RIGHT_A;
			end
			ST_ADD: begin
				if (status.add_last) begin
					if (is_query_q) begin
						state_d = status.cnt_zero ? ST_Q_POP : ST_Q_A;
					end else if (leaf_q || status.cnt_zero) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_RIGHT_A;
					end
				end
			end
			ST_RIGHT_A: state_d = ST_RIGHT_D;
			ST_RIGHT_D: begin
				if (!status.rdata_zero) state_d = ST_ADD;
				else if (status.cnt_zero) state_d = ST_WRITE;
				else state_d = ST_RIGHT_A;
			end
			ST_WRITE: if (status.cnt_zero) state_d = ST_POP;
			ST_POP: state_d = status.sp_zero ? ST_IDLE : ST_LOAD_A;
			ST_Q_START: state_d = status.q_empty ? ST_OUT : ST_Q_POP;
			ST_Q_POP: state_d = status.sp_zero ? ST_MAX : ST_Q_CHK;
			ST_Q_CHK: begin
				if (!status.q_disjoint && status.q_contained) state_d = ST_Q_A;
				else state_d = ST_Q_POP;
			end
			ST_Q_A: state_d = ST_Q_D;
			ST_Q_D: begin
				if (!status.rdata_zero) state_d = ST_ADD;
				else if (status.cnt_zero) state_d = ST_Q_POP;
				else state_d = ST_Q_A;
			end
			ST_MAX: if (status.cnt_zero) state_d = ST_OUT;
			ST_OUT: if (rsp_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we) state_d = ST_CLEAR;
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		cmd.src   = SRC_CUR;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_DOWN: begin
				cmd.push_down = !status.leaf;
				cmd.cnt_init  = status.leaf;
			end
			ST_LOAD_A: cmd.src = leaf_q ? SRC_CUR : SRC_LEFT;
			ST_LOAD_D: begin
				cmd.src      = leaf_q ? SRC_CUR : SRC_LEFT;
				cmd.ld_work  = 1'b1;
				cmd.cnt_dec  = !status.cnt_zero;
				cmd.v_ins    = status.cnt_zero && leaf_q;
				cmd.cnt_init = status.cnt_zero && !leaf_q;
			end
			ST_ADD: begin
				cmd.add_step = 1'b1;
				if (status.add_last) begin
					if (is_query_q) begin
						cmd.cnt_dec = !status.cnt_zero;
					end else if (leaf_q || status.cnt_zero) begin
						cmd.cnt_init = 1'b1;
					end else begin
						cmd.cnt_dec = 1'b1;
					end
				end
			end
			ST_RIGHT_A: cmd.src = SRC_RIGHT;
			ST_RIGHT_D: begin
				cmd.src = SRC_RIGHT;
				if (!status.rdata_zero) cmd.v_mem = 1'b1;
				else if (status.cnt_zero) cmd.cnt_init = 1'b1;
				else cmd.cnt_dec = 1'b1;
			end
			ST_WRITE: begin
				cmd.mem_wr  = 1'b1;
				cmd.cnt_dec = !status.cnt_zero;
			end
			ST_POP: begin
				cmd.pop      = !status.sp_zero;
				cmd.cnt_init = 1'b1;
			end
			ST_Q_START: ;
			ST_Q_POP: begin
				cmd.pop      = !status.sp_zero;
				cmd.cnt_init = status.sp_zero;
			end
			ST_Q_CHK: begin
				cmd.cnt_init = !status.q_disjoint && status.q_contained;
				cmd.q_split  = !status.q_disjoint && !status.q_contained;
			end
			ST_Q_A: ;
			ST_Q_D: begin
				if (!status.rdata_zero) cmd.v_mem = 1'b1;
				else if (!status.cnt_zero) cmd.cnt_dec = 1'b1;
			end
			ST_MAX: begin
				cmd.max_step = 1'b1;
				cmd.cnt_dec  = !status.cnt_zero;
			end
			ST_OUT: rsp_valid = 1'b1;
			default: ;
		endcase
	end

	// state and mode flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			is_query_q <= 1'b0;
			leaf_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				is_query_q <= req_cmd;
				leaf_q     <= 1'b0;
			end
			if (state_q == ST_DOWN && status.leaf) leaf_q <= 1'b1;
			if (state_q == ST_POP) leaf_q <= 1'b0;
		end
	end
endmodule

FILE: src/range_xor_basis_max.sv
// after reset, and after every bucket_count write, a clearing pass sweeps the tree store
// one word a cycle; no item is taken meanwhile
// one item at a time: an insert walks about ten levels; at each node it loads the basis,
// runs the serial elimination and writes the basis back
// a query pops each visited node, loads each covering node's basis, eliminates every stored
// vector and builds the maximum, all through the one-read tree memory and serial eliminator
module range_xor_basis_max (
	input  logic               clk,
	input  logic               arst_n,
	rxbm_req_if.sink           req,
	rxbm_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  rxbm_pkg::idx_t     cfg_wdata
);
	import rxbm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	rxbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_cmd  (req.cmd),
		.rsp_ready(rsp.ready),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid)
	);

	// tree store and basis arithmetic
	rxbm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_cmd     (req.cmd),
		.bucket_index(req.bucket_index),
		.insert_value(req.insert_value),
		.range_left  (req.range_left),
		.range_right (req.range_right),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.status      (status),
		.max_xor     (rsp.max_xor)
	);
endmodule

FILE: test/rxbm_checker.sv
module rxbm_checker
	import rxbm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rxbm_req_if  req,
	rxbm_rsp_if  rsp,
	input  logic cfg_we,
	input  idx_t cfg_wdata,
	output int   fails,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NODES   = 4 * NUM_BUCKETS;
	// node 0 is never part of the tree, so it serves as the query scratch basis
	localparam int unsigned SCRATCH = 0;

	value_t      basis_store [NODES][VALUE_BITS];
	int unsigned bucket_count;
	value_t      max_xor_q [$];

	function automatic void clear_store();
		for (int n = 0; n < NODES; n++)
			for (int j = 0; j < VALUE_BITS; j++)
				basis_store[n][j] = '0;
	endfunction

	// gaussian elimination of one vector into a node basis
	function automatic void basis_add(int unsigned nd, value_t v);
		for (int j = VALUE_BITS - 1; j >= 0 && v != 0; j--) begin
			if (v[j]) begin
				if (basis_store[nd][j] != 0) begin
					v ^= basis_store[nd][j];
				end else begin
					basis_store[nd][j] = v;
					return;
				end
			end
		end
	endfunction

	// descend to the leaf, then rebuild each ancestor from its children
	function automatic void tree_insert(int unsigned nd, int unsigned l, int unsigned r,
		int unsigned p, value_t v);
		int unsigned m, lc, rc;
		if (nd >= NODES)
			return;
		if (l == r) begin
			basis_add(nd, v);
			return;
		end
		m  = (l + r) >> 1;
		lc = nd * 2;
		rc = lc + 1;
		if (p <= m)
			tree_insert(lc, l, m, p, v);
		else
			tree_insert(rc, m + 1, r, p, v);
		if (rc >= NODES)
			return;
		for (int i = 0; i < VALUE_BITS; i++)
			basis_store[nd][i] = basis_store[lc][i];
		for (int i = VALUE_BITS - 1; i >= 0; i--)
			if (basis_store[rc][i] != 0)
				basis_add(nd, basis_store[rc][i]);
	endfunction

	// fold every covering node into the scratch basis
	function automatic void tree_gather(int unsigned nd, int unsigned l, int unsigned r,
		int unsigned lo, int unsigned hi);
		int unsigned m;
		if (nd >= NODES)
			return;
		if (lo <= l && r <= hi) begin
			for (int i = VALUE_BITS - 1; i >= 0; i--)
				if (basis_store[nd][i] != 0)
					basis_add(SCRATCH, basis_store[nd][i]);
			return;
		end
		m = (l + r) >> 1;
		if (hi <= m) begin
			tree_gather(nd * 2, l, m, lo, hi);
		end else if (lo > m) begin
			tree_gather(nd * 2 + 1, m + 1, r, lo, hi);
		end else begin
			tree_gather(nd * 2, l, m, lo, m);
			tree_gather(nd * 2 + 1, m + 1, r, m + 1, hi);
		end
	endfunction

	function automatic value_t range_max_xor(idx_t left, idx_t right);
		int unsigned lo, hi;
		value_t acc, t;
		for (int j = 0; j < VALUE_BITS; j++)
			basis_store[SCRATCH][j] = '0;
		lo  = (left < 1) ? 1 : left;
		hi  = (right > bucket_count) ? bucket_count : right;
		acc = '0;
		if (lo <= hi) begin
			tree_gather(1, 1, bucket_count, lo, hi);
			for (int j = VALUE_BITS - 1; j >= 0; j--) begin
				t = acc ^ basis_store[SCRATCH][j];
				if (t > acc)
					acc = t;
			end
		end
		return acc;
	endfunction

	// watch the channels and the register port
	always @(posedge clk or negedge arst_n) begin
		value_t want;
		if (!arst_n) begin
			clear_store();
			bucket_count = NUM_BUCKETS;
			max_xor_q.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				bucket_count = (cfg_wdata == 0) ? 1 :
					(cfg_wdata > NUM_BUCKETS) ? NUM_BUCKETS : cfg_wdata;
				clear_store();
			end
			if (req.valid && req.ready) begin
				if (req.cmd == 1'b0) begin
					if (req.bucket_index >= 1 && req.bucket_index <= bucket_count &&
						req.insert_value != 0)
						tree_insert(1, 1, bucket_count, req.bucket_index, req.insert_value);
				end else begin
					max_xor_q.push_back(range_max_xor(req.range_left, req.range_right));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (max_xor_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result max_xor=%h", rsp.max_xor);
				end else begin
					want = max_xor_q.pop_front();
					if (rsp.max_xor !== want) begin
						fails++;
						if (fails <= 10)
							$display("max_xor mismatch: expected %h actual %h",
								want, rsp.max_xor);
					end
				end
			end
			pending = max_xor_q.size();
		end
	end
endmodule

FILE: test/tb_range_xor_basis_max.sv
module tb_range_xor_basis_max;
	import rxbm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// an insert may still be running when the last query result arrives
	localparam int INSERT_SETTLE = 15000;
	localparam int STALL_LIMIT   = 600000;
	localparam int LONG_HOLD     = 2000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	idx_t cfg_wdata;
	int   fails;
	int   pending;
	bit   idle_on;
	bit   long_hold;

	rxbm_req_if req_ch();
	rxbm_rsp_if rsp_ch();

	range_xor_basis_max u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rxbm_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles with no item moving
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_item(logic c, idx_t idx, value_t v, idx_t l, idx_t r);
		@(negedge clk);
		req_ch.valid        = 1'b1;
		req_ch.cmd          = c;
		req_ch.bucket_index = idx;
		req_ch.insert_value = v;
		req_ch.range_left   = l;
		req_ch.range_right  = r;
		do @(posedge clk); while (!req_ch.ready);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat ($urandom_range(0, 14)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_buckets(idx_t n);
		drain();
		repeat (INSERT_SETTLE) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = n;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = idx_t'($urandom());
	endtask

	// mostly well-formed inserts and queries, some noise on the indices
	task automatic random_item(int unsigned bc);
		logic   c;
		idx_t   idx, l, r, t;
		value_t v;
		c = ($urandom_range(0, 9) < 6) ? 1'b0 : 1'b1;
		idx = ($urandom_range(0, 9) == 0) ? idx_t'($urandom_range(0, 2047))
			: idx_t'($urandom_range(1, bc));
		case ($urandom_range(0, 4))
			0: v = value_t'($urandom());
			1: v = value_t'($urandom_range(0, 255));
			2: v = value_t'(1) << $urandom_range(0, 30);
			3: v = value_t'($urandom() & 32'h7000_000f);
			default: v = ($urandom_range(0, 3) == 0) ? '0 : value_t'($urandom());
		endcase
		if ($urandom_range(0, 7) == 0) begin
			l = idx_t'($urandom_range(0, 2047));
			r = idx_t'($urandom_range(0, 2047));
		end else begin
			l = idx_t'($urandom_range(1, bc));
			r = idx_t'($urandom_range(1, bc));
			if (l > r && $urandom_range(0, 3) != 0) begin
				t = l;
				l = r;
				r = t;
			end
		end
		send_item(c, idx, v, l, r);
	endtask

	initial begin
		idle_on             = 1'b1;
		long_hold           = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = 1'b0;
		req_ch.bucket_index = '0;
		req_ch.insert_value = '0;
		req_ch.range_left   = '0;
		req_ch.range_right  = '0;
		arst_n              = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, ignored indices, zero value, clipped and reversed ranges
		send_item(1'b1, 11'd0, '0, 11'd1, 11'd1024);
		send_item(1'b0, 11'd1, 31'h7fff_ffff, 11'd0, 11'd0);
		send_item(1'b0, 11'd1024, 31'h1, 11'd0, 11'd0);
		send_item(1'b0, 11'd512, 31'h4000_0000, 11'd0, 11'd0);
		send_item(1'b0, 11'd0, 31'h5, 11'd0, 11'd0);
		send_item(1'b0, 11'd1025, 31'h3, 11'd0, 11'd0);
		send_item(1'b0, 11'd2047, 31'h7fff_ffff, 11'd2047, 11'd2047);
		send_item(1'b0, 11'd3, 31'h0, 11'd0, 11'd0);
		send_item(1'b0, 11'd2, 31'h7fff_ffff, 11'd0, 11'd0);
		send_item(1'b0, 11'd2, 31'h2aaa_aaaa, 11'd0, 11'd0);
		send_item(1'b1, 11'd0, '0, 11'd1, 11'd1024);
		send_item(1'b1, 11'd2047, 31'h7fff_ffff, 11'd0, 11'd2047);
		send_item(1'b1, 11'd0, '0, 11'd2, 11'd1);
		send_item(1'b1, 11'd0, '0, 11'd1024, 11'd1024);
		send_item(1'b1, 11'd0, '0, 11'd0, 11'd0);
		send_item(1'b1, 11'd0, '0, 11'd2047, 11'd2047);
		send_item(1'b1, 11'd0, '0, 11'd512, 11'd512);
		send_item(1'b1, 11'd0, '0, 11'd3, 11'd1023);
		send_item(1'b1, 11'd0, '0, 11'd1, 11'd2);
		repeat (40) random_item(1024);

		// zero register value is taken as one bucket
		set_buckets(11'd0);
		repeat (40) random_item(1);

		set_buckets(11'd13);
		repeat (60) random_item(13);
		long_hold = 1'b1;
		repeat (20) random_item(13);
		drain();
		repeat (170) random_item(13);

		// oversized register value is taken as the full tree
		set_buckets(11'd2047);
		repeat (60) random_item(1024);

		set_buckets(11'd100);
		repeat (60) random_item(100);
		idle_on = 1'b0;
		repeat (110) random_item(100);

		drain();
		repeat (INSERT_SETTLE) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
